FILE: rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
`default_nettype none

package hcbd_pkg;

   // Parser phases
   localparam logic [2:0] PH_WS   = 3'd0;
   localparam logic [2:0] PH_NUM  = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_CR   = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SIZE_ERR = 2'd1;
   localparam logic [1:0] STATUS_TRUNC    = 2'd2;

   // Characters the size line parser looks for
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HT    = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // Control part of the parser state
   typedef struct packed {
      logic [2:0] phase;
      logic       digit_seen;
      logic       prefix_zero_seen;
      logic [1:0] error_code;
   } hcbd_ctrl_type;

   // Flags of one result item
   typedef struct packed {
      logic       payload_valid;
      logic       decode_done;
      logic [1:0] decode_status;
   } hcbd_flags_type;

   localparam hcbd_ctrl_type CTRL_RESET = '{
      phase: PH_WS, digit_seen: 1'b0, prefix_zero_seen: 1'b0, error_code: STATUS_OK
   };

endpackage

`default_nettype wire

FILE: rtl/hcbd_if.sv
// Valid/ready channel interfaces for body bytes and decoded result items.
`default_nettype none

interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_end;

   modport source (output valid, output body_byte, output body_end, input ready);
   modport sink   (input valid, input body_byte, input body_end, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       decode_done;
   logic [1:0] decode_status;

   modport source (output valid, output payload_byte, output payload_valid,
                   output decode_done, output decode_status, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input decode_done, input decode_status, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcbd_step.sv
// Next-state and result logic of the chunked body parser for one byte.
`default_nettype none

module hcbd_step #(
   parameter int SIZE_BITS = 32
) (
   input  hcbd_pkg::hcbd_ctrl_type  cur_ctrl,
   input  logic [SIZE_BITS-1:0]     cur_accum,
   input  logic [SIZE_BITS-1:0]     cur_left,
   input  logic [7:0]               body_byte,
   input  logic                     body_end,
   output hcbd_pkg::hcbd_ctrl_type  nxt_ctrl,
   output logic [SIZE_BITS-1:0]     nxt_accum,
   output logic [SIZE_BITS-1:0]     nxt_left,
   output hcbd_pkg::hcbd_flags_type flags
);

   logic                 is_space;
   logic                 is_hex;
   logic [3:0]           hex_val;
   logic                 is_x;
   logic                 take_size;
   logic [SIZE_BITS-1:0] base_accum;
   logic                 base_digit;
   logic                 base_pzero;
   logic [SIZE_BITS-1:0] left_dec;
   hcbd_pkg::hcbd_ctrl_type ctrl_w;
   logic [SIZE_BITS-1:0] accum_w;
   logic [SIZE_BITS-1:0] left_w;
   logic                 valid_w;

   // Classify the byte
   always_comb begin
      is_space = (body_byte == hcbd_pkg::CHAR_SPACE) ||
                 (body_byte >= hcbd_pkg::CHAR_HT && body_byte <= hcbd_pkg::CHAR_CR);
      is_x     = (body_byte == hcbd_pkg::CHAR_LOW_X) || (body_byte == hcbd_pkg::CHAR_UP_X);
      is_hex   = 1'b0;
      hex_val  = 4'd0;
      if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
         is_hex  = 1'b1;
         hex_val = body_byte[3:0];
      end else if ((body_byte >= 8'h61 && body_byte <= 8'h66) ||
                   (body_byte >= 8'h41 && body_byte <= 8'h46)) begin
         is_hex  = 1'b1;
         hex_val = body_byte[3:0] + 4'd9;
      end
   end

   // A size line starts fresh on its first non-space byte
   assign base_accum = (cur_ctrl.phase == hcbd_pkg::PH_WS) ? '0 : cur_accum;
   assign base_digit = (cur_ctrl.phase == hcbd_pkg::PH_WS) ? 1'b0 : cur_ctrl.digit_seen;
   assign base_pzero = (cur_ctrl.phase == hcbd_pkg::PH_WS) ? 1'b0 : cur_ctrl.prefix_zero_seen;
   assign left_dec   = cur_left - SIZE_BITS'(1);

   always_comb begin
      ctrl_w    = cur_ctrl;
      accum_w   = cur_accum;
      left_w    = cur_left;
      valid_w   = 1'b0;
      take_size = 1'b0;

      case (cur_ctrl.phase)
         hcbd_pkg::PH_WS: begin
            if (!is_space) begin
               accum_w                 = '0;
               ctrl_w.digit_seen       = 1'b0;
               ctrl_w.prefix_zero_seen = 1'b0;
               if (body_byte == hcbd_pkg::CHAR_PLUS) begin
                  ctrl_w.phase = hcbd_pkg::PH_NUM;
               end else if (body_byte == hcbd_pkg::CHAR_MINUS) begin
                  ctrl_w.error_code = hcbd_pkg::STATUS_SIZE_ERR;
                  ctrl_w.phase      = hcbd_pkg::PH_DONE;
               end else begin
                  ctrl_w.phase = hcbd_pkg::PH_NUM;
                  take_size    = 1'b1;
               end
            end
         end
         hcbd_pkg::PH_NUM: begin
            take_size = 1'b1;
         end
         hcbd_pkg::PH_EXT: begin
            if (body_byte == hcbd_pkg::CHAR_CR) begin
               ctrl_w.phase = hcbd_pkg::PH_CR;
            end
         end
         hcbd_pkg::PH_CR: begin
            if (body_byte == hcbd_pkg::CHAR_LF) begin
               ctrl_w.phase = hcbd_pkg::PH_DATA;
            end else if (body_byte != hcbd_pkg::CHAR_CR) begin
               ctrl_w.phase = hcbd_pkg::PH_EXT;
            end
         end
         hcbd_pkg::PH_DATA: begin
            valid_w = 1'b1;
            left_w  = left_dec;
            if (left_dec == '0) begin
               ctrl_w.phase = hcbd_pkg::PH_WS;
            end else if (body_end) begin
               ctrl_w.error_code = hcbd_pkg::STATUS_TRUNC;
               ctrl_w.phase      = hcbd_pkg::PH_DONE;
            end
         end
         default: begin
            ctrl_w.phase = hcbd_pkg::PH_DONE;
         end
      endcase

      // Size line character: digit, prefix x, or end of the number
      if (take_size) begin
         if (is_hex) begin
            if (base_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
               ctrl_w.error_code = hcbd_pkg::STATUS_SIZE_ERR;
               ctrl_w.phase      = hcbd_pkg::PH_DONE;
            end else begin
               accum_w                 = {base_accum[SIZE_BITS-5:0], hex_val};
               ctrl_w.prefix_zero_seen = !base_digit && (hex_val == 4'd0);
               ctrl_w.digit_seen       = 1'b1;
            end
         end else if (is_x && base_pzero) begin
            ctrl_w.prefix_zero_seen = 1'b0;
         end else if (!base_digit || base_accum == '0) begin
            ctrl_w.phase = hcbd_pkg::PH_DONE;
         end else begin
            left_w       = base_accum;
            ctrl_w.phase = (body_byte == hcbd_pkg::CHAR_CR) ? hcbd_pkg::PH_CR
                                                            : hcbd_pkg::PH_EXT;
         end
      end
   end

   // Report, then drop all state after the last byte of a body
   assign flags.payload_valid = valid_w;
   assign flags.decode_done   = (ctrl_w.phase == hcbd_pkg::PH_DONE) || body_end;
   assign flags.decode_status = ctrl_w.error_code;

   assign nxt_ctrl  = body_end ? hcbd_pkg::CTRL_RESET : ctrl_w;
   assign nxt_accum = body_end ? '0 : accum_w;
   assign nxt_left  = body_end ? '0 : left_w;

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder_core.sv
// Top level of the HTTP chunked body decoder: input register, parser, result register.
//
//   channel | dir | handshake     | item
//   req     | in  | valid / ready | body_byte, body_end
//   rsp     | out | valid / ready | payload_byte, payload_valid, decode_done, decode_status
//
// One result item per body byte. An item passes through the input register and then the
// result register before it appears on rsp; one item per cycle is sustained while rsp is
// ready, as the parser state update between the two registers is combinational.
// Reset (synchronous) returns the parser to whitespace skipping and empties both stages.
// A stalled rsp holds its item; req stays ready while the input register can move on.
`default_nettype none

module http_chunked_body_decoder_core #(
   parameter int SIZE_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   hcbd_req_if.sink req,
   hcbd_rsp_if.source rsp
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Parser state
   hcbd_pkg::hcbd_ctrl_type ctrl_ff, ctrl_in;
   logic [SIZE_BITS-1:0]    accum_ff, accum_in;
   logic [SIZE_BITS-1:0]    left_ff, left_in;

   // Result register
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_byte_ff;
   hcbd_pkg::hcbd_flags_type out_flags_ff;
   hcbd_pkg::hcbd_flags_type step_flags;

   logic out_free;
   logic in_free;
   logic step_fire;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign in_free   = !in_valid_ff || out_free;
   assign step_fire = in_valid_ff && out_free;

   assign req.ready    = in_free;
   assign in_valid_in  = in_free ? req.valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   hcbd_step #(
      .SIZE_BITS(SIZE_BITS)
   ) u_step (
      .cur_ctrl (ctrl_ff),
      .cur_accum(accum_ff),
      .cur_left (left_ff),
      .body_byte(in_byte_ff),
      .body_end (in_end_ff),
      .nxt_ctrl (ctrl_in),
      .nxt_accum(accum_in),
      .nxt_left (left_in),
      .flags    (step_flags)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= hcbd_pkg::CTRL_RESET;
         accum_ff     <= '0;
         left_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            ctrl_ff  <= ctrl_in;
            accum_ff <= accum_in;
            left_ff  <= left_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_free) begin
         in_byte_ff <= req.body_byte;
         in_end_ff  <= req.body_end;
      end
      if (out_free) begin
         out_byte_ff  <= step_flags.payload_valid ? in_byte_ff : 8'd0;
         out_flags_ff <= step_flags;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.payload_byte  = out_byte_ff;
   assign rsp.payload_valid = out_flags_ff.payload_valid;
   assign rsp.decode_done   = out_flags_ff.decode_done;
   assign rsp.decode_status = out_flags_ff.decode_status;

`ifndef SYNTHESIS
   // Non-payload items carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.payload_valid |-> rsp.payload_byte == 8'd0)
      else $error("non-payload item with nonzero byte");

   // Chunk data phase always has bytes still due
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.phase == hcbd_pkg::PH_DATA |-> left_ff != '0)
      else $error("data phase with no bytes left");

   // Last byte of a body returns the parser to its reset state
   a_end_reset: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_end_ff |=> ctrl_ff == hcbd_pkg::CTRL_RESET && left_ff == '0)
      else $error("parser state not cleared after last byte");

   // After decoding ends every item reports done and no payload
   a_done_item: assert property (@(posedge clock) disable iff (reset)
      step_fire && ctrl_ff.phase == hcbd_pkg::PH_DONE
      |=> rsp.valid && rsp.decode_done && !rsp.payload_valid)
      else $error("item after end of decoding not marked done");
`endif

endmodule

`default_nettype wire
